/* rtl/ws44_pkg.sv */
package ws44_pkg;

    localparam int MAX_COLS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int ROWS_CAP    = 256;
    localparam int WIN         = 4;
    localparam int DIM_MIN     = 4;
    localparam int DIM_BITS    = 9;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(ROWS_CAP);
    localparam int CORE_BITS   = 18;
    localparam int RING_BITS   = 20;
    localparam int DIM_RESET   = 64;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first_of_matrix;
    } t_in_word;

    typedef struct packed {
        logic signed [CORE_BITS-1:0] core_sum;
        logic signed [RING_BITS-1:0] ring_sum;
        logic                        last_result;
    } t_out_word;

    // oldest row first
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ls0;
        logic signed [SAMPLE_BITS-1:0] ls1;
        logic signed [SAMPLE_BITS-1:0] ls2;
    } t_line_word;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                due;
        logic                last;
    } t_pos;

    typedef struct packed {
        logic                en;
        logic [COL_BITS-1:0] addr;
        t_line_word          word;
    } t_line_wr;

    // partial sums of one window column
    typedef struct packed {
        logic signed [SAMPLE_BITS:0]   top_bot;
        logic signed [SAMPLE_BITS:0]   mid;
        logic signed [SAMPLE_BITS+1:0] full;
    } t_col;

endpackage

/* rtl/ws44_pos.sv */
module ws44_pos
    import ws44_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_first,
    input  logic [DIM_BITS-1:0] i_rows,
    input  logic [DIM_BITS-1:0] i_cols,
    output t_pos                o_pos
);

    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] row_now;
    logic [COL_BITS-1:0] col_now;
    logic [DIM_BITS-1:0] rows, cols, last_row, last_col;

    always_comb begin
        if (i_rows < DIM_BITS'(DIM_MIN)) begin
            rows = DIM_BITS'(DIM_MIN);
        end else if (i_rows > DIM_BITS'(ROWS_CAP)) begin
            rows = DIM_BITS'(ROWS_CAP);
        end else begin
            rows = i_rows;
        end
        if (i_cols < DIM_BITS'(DIM_MIN)) begin
            cols = DIM_BITS'(DIM_MIN);
        end else if (i_cols > DIM_BITS'(MAX_COLS)) begin
            cols = DIM_BITS'(MAX_COLS);
        end else begin
            cols = i_cols;
        end
        last_row = rows - DIM_BITS'(1);
        last_col = cols - DIM_BITS'(1);

        row_now = i_first ? '0 : r_row;
        col_now = i_first ? '0 : r_col;

        o_pos.col  = col_now;
        o_pos.due  = (row_now >= ROW_BITS'(WIN - 1)) && (col_now >= COL_BITS'(WIN - 1));
        o_pos.last = (DIM_BITS'(row_now) == last_row) && (DIM_BITS'(col_now) == last_col);

        // a counter at or past the last index wraps after this word
        if (DIM_BITS'(col_now) >= last_col) begin
            n_col = '0;
            if (DIM_BITS'(row_now) >= last_row) begin
                n_row = '0;
            end else begin
                n_row = row_now + ROW_BITS'(1);
            end
        end else begin
            n_col = col_now + COL_BITS'(1);
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_step) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

/* rtl/ws44_line.sv */
module ws44_line
    import ws44_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [COL_BITS-1:0] i_rd_addr,
    input  t_line_wr            i_wr,
    output t_line_word          o_word,
    output logic                o_clr_busy
);

    t_line_word          mem [MAX_COLS];
    t_line_word          r_rd_word;
    t_line_word          r_byp_word;
    logic                r_byp;
    logic                r_clr_busy;
    logic [COL_BITS-1:0] r_clr_addr;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;
    t_line_word          wr_word;

    always_comb begin
        wr_en   = r_clr_busy || i_wr.en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr.addr;
        wr_word = r_clr_busy ? '0 : i_wr.word;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    // same column written back while it is read: take the new word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_byp_word <= i_wr.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + COL_BITS'(1);
            if (r_clr_addr == COL_BITS'(MAX_COLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_word     = r_byp ? r_byp_word : r_rd_word;
    assign o_clr_busy = r_clr_busy;

endmodule

/* rtl/ws44_window.sv */
module ws44_window
    import ws44_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  t_line_word                    i_word,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [CORE_BITS-1:0]   o_core,
    output logic signed [RING_BITS-1:0]   o_ring
);

    t_col r_col [WIN];
    t_col n_col;

    always_comb begin
        n_col.top_bot = (SAMPLE_BITS+1)'(i_word.ls0) + (SAMPLE_BITS+1)'(i_sample);
        n_col.mid     = (SAMPLE_BITS+1)'(i_word.ls1) + (SAMPLE_BITS+1)'(i_word.ls2);
        n_col.full    = (SAMPLE_BITS+2)'(n_col.top_bot) + (SAMPLE_BITS+2)'(n_col.mid);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_col[i] <= r_col[i+1];
            end
            r_col[WIN-1] <= n_col;
        end
    end

    // core is the middle of the two inner columns, ring is everything else
    always_comb begin
        o_core = CORE_BITS'(r_col[1].mid) + CORE_BITS'(r_col[2].mid);
        o_ring = (RING_BITS'(r_col[0].full) + RING_BITS'(r_col[WIN-1].full))
               + (RING_BITS'(r_col[1].top_bot) + RING_BITS'(r_col[2].top_bot));
    end

endmodule

/* rtl/window_core_ring_sums_4x4_top.sv */
// 4x4 sliding-window core and ring sums over a row-major matrix of signed Q8.8 words.
// One word is taken every cycle while o_ready is high; a result leaves through the registered
// stages line buffer read, column sums and window sum after the word that completes its window,
// and only words at row >= 3 and column >= 3 give one. The three line buffers share one
// 256-entry memory, one column per entry; after reset a clearing pass writes every entry to
// zero, during which o_ready stays low (register writes are taken as usual). A stall on the
// result side holds the whole pipeline. rows_in_use sits at byte address 0 and cols_in_use
// at 4; both are clamped to 4..256 and read on every word.
module window_core_ring_sums_4x4_top
    import ws44_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_in_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_BITS-1:0] r_rows, r_cols;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    logic                advance;
    logic                accept;
    logic                clr_busy;
    t_pos                pos;

    logic                          r_a_vld;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic [COL_BITS-1:0]           r_a_addr;
    logic                          r_a_due;
    logic                          r_a_last;
    logic                          r_b_vld;
    logic                          r_b_last;
    logic                          r_out_vld;
    t_out_word                     r_out_word;

    t_line_word                  line_word;
    t_line_wr                    line_wr;
    logic                        a_move;
    logic signed [CORE_BITS-1:0] core;
    logic signed [RING_BITS-1:0] ring;

    // configuration
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_ROWS: prdata = 32'(r_rows);
            REG_COLS: prdata = 32'(r_cols);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_BITS'(DIM_RESET);
            r_cols <= DIM_BITS'(DIM_RESET);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ROWS: r_rows <= pwdata[DIM_BITS-1:0];
                REG_COLS: r_cols <= pwdata[DIM_BITS-1:0];
                default:  ;
            endcase
        end
    end

    // pipeline control
    assign advance = !r_out_vld || i_ready;
    assign o_ready = advance && !clr_busy;
    assign accept  = i_valid && o_ready;
    assign a_move  = r_a_vld && advance;

    ws44_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_first (i_in_word.first_of_matrix),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_pos   (pos)
    );

    always_comb begin
        line_wr.en       = a_move;
        line_wr.addr     = r_a_addr;
        line_wr.word.ls0 = line_word.ls1;
        line_wr.word.ls1 = line_word.ls2;
        line_wr.word.ls2 = r_a_sample;
    end

    ws44_line u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (pos.col),
        .i_wr       (line_wr),
        .o_word     (line_word),
        .o_clr_busy (clr_busy)
    );

    ws44_window u_window (
        .i_clk    (i_clk),
        .i_shift  (a_move),
        .i_word   (line_word),
        .i_sample (r_a_sample),
        .o_core   (core),
        .o_ring   (ring)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld   <= accept;
            r_b_vld   <= r_a_vld && r_a_due;
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_sample <= i_in_word.sample;
            r_a_addr   <= pos.col;
            r_a_due    <= pos.due;
            r_a_last   <= pos.last;
        end
        if (a_move) begin
            r_b_last <= r_a_last;
        end
        if (advance && r_b_vld) begin
            r_out_word.core_sum    <= core;
            r_out_word.ring_sum    <= ring;
            r_out_word.last_result <= r_b_last;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_word = r_out_word;

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ws44_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_word    i_in_word;
    logic        o_valid;
    logic        i_ready;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    window_core_ring_sums_4x4_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // matrix words waiting to be sent, and window sums still owed by the block
    t_in_word  word_queue[$];
    t_out_word sums_due[$];
    t_out_word due_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    bit in_taken = 1'b0;

    // shadow of the block: line buffers, window, position and dimension registers
    logic signed [SAMPLE_BITS-1:0] line_buf [3][MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] win [4][4];
    int             row_pos = 0;
    int             col_pos = 0;
    logic [DIM_BITS-1:0] rows_reg = DIM_BITS'(DIM_RESET);
    logic [DIM_BITS-1:0] cols_reg = DIM_BITS'(DIM_RESET);

    initial begin
        foreach (line_buf[i, j]) line_buf[i][j] = '0;
        foreach (win[i, j]) win[i][j] = '0;
    end

    function automatic int dim_clamp(input logic [DIM_BITS-1:0] v, input int hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic void fold_window(input t_in_word w);
        int        n_rows;
        int        n_cols;
        int        r;
        int        c;
        int        total;
        int        core;
        t_out_word res;
        n_rows = dim_clamp(rows_reg, ROWS_CAP);
        n_cols = dim_clamp(cols_reg, MAX_COLS);
        if (w.first_of_matrix) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (c > MAX_COLS - 1) c = MAX_COLS - 1;

        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = win[i][j + 1];
        for (int i = 0; i < 3; i++)
            win[i][3] = line_buf[i][c];
        win[3][3] = w.sample;

        line_buf[0][c] = line_buf[1][c];
        line_buf[1][c] = line_buf[2][c];
        line_buf[2][c] = w.sample;

        if (r >= 3 && c >= 3) begin
            total = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    total += win[i][j];
            core = win[1][1] + win[1][2] + win[2][1] + win[2][2];
            res.core_sum    = CORE_BITS'(core);
            res.ring_sum    = RING_BITS'(total - core);
            res.last_result = (r == n_rows - 1) && (c == n_cols - 1);
            sums_due.insert(sums_due.size(), res);
        end

        // compare the live counter, so a shrunk width wraps after this word
        if (col_pos >= n_cols - 1) begin
            col_pos = 0;
            if (row_pos >= n_rows - 1) row_pos = 0;
            else row_pos++;
        end else begin
            col_pos++;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // driver: new word only once the previous one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_word <= word_queue.pop_front();
                i_valid   <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check results first, then predict from the accepted word
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (sums_due.size() == 0) begin
                flag_mismatch($sformatf("result with none due: core %0d ring %0d last %0d",
                    o_out_word.core_sum, o_out_word.ring_sum, o_out_word.last_result));
            end else begin
                due_word = sums_due.pop_front();
                if (o_out_word.core_sum !== due_word.core_sum)
                    flag_mismatch($sformatf("core_sum got %0d, expected %0d",
                        o_out_word.core_sum, due_word.core_sum));
                if (o_out_word.ring_sum !== due_word.ring_sum)
                    flag_mismatch($sformatf("ring_sum got %0d, expected %0d",
                        o_out_word.ring_sum, due_word.ring_sum));
                if (o_out_word.last_result !== due_word.last_result)
                    flag_mismatch($sformatf("last_result got %0d, expected %0d",
                        o_out_word.last_result, due_word.last_result));
            end
        end
        in_taken = i_valid && o_ready;
        if (in_taken) fold_window(i_in_word);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [DIM_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // address still selects the register, so the read shows the new value
        if (!pready || prdata !== 32'(value))
            flag_mismatch($sformatf("register %0d reads %0d after writing %0d",
                idx, prdata, value));
        case (idx)
            REG_ROWS: rows_reg = value;
            REG_COLS: cols_reg = value;
            default:  ;
        endcase
    endtask

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            IDLE_BOTH: begin send_idle_pct = 23; recv_stall_pct = 23; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic push_word(input logic signed [SAMPLE_BITS-1:0] s, input logic first);
        t_in_word w;
        w.sample          = s;
        w.first_of_matrix = first;
        word_queue.insert(word_queue.size(), w);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_BITS'($signed($urandom_range(0, 1023)) - 512);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // whole matrices at the current dimensions; the last one is cut short
    // when the budget runs out, leaving the counters mid-matrix
    task automatic queue_matrices(input int n_words);
        int  pushed;
        int  size;
        int  take;
        bit  flagged;
        pushed = 0;
        while (pushed < n_words) begin
            size    = dim_clamp(rows_reg, ROWS_CAP) * dim_clamp(cols_reg, MAX_COLS);
            take    = (size < n_words - pushed) ? size : n_words - pushed;
            flagged = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < take; k++)
                push_word(pick_sample(),
                          (k == 0 && flagged) || ($urandom_range(0, 99) == 0));
            pushed += take;
        end
    endtask

    task automatic wait_drained();
        while (word_queue.size() > 0 || i_valid || sums_due.size() > 0)
            @(negedge i_clk);
        // words that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_in_word = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // dimensions below range clamp to 4x4
        set_idle(IDLE_NONE);
        write_reg(REG_ROWS, 9'd0);
        write_reg(REG_COLS, 9'd3);
        for (int k = 0; k < 16; k++) push_word(16'sh7fff, k == 0);
        // no start flag: the row counter wraps into a new matrix
        for (int k = 0; k < 16; k++) push_word(16'sh8000, 1'b0);
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            set_idle(t_idle_mode'(p % 4));
            write_reg(REG_ROWS, DIM_BITS'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 3) : $urandom_range(4, 8)));
            write_reg(REG_COLS, DIM_BITS'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 3) : $urandom_range(4, 12)));
            queue_matrices(28);
            wait_drained();
        end

        // widest row: three narrow rows, then an above-range width clamps to
        // the full line buffer for the bottom row of the matrix
        set_idle(IDLE_BOTH);
        write_reg(REG_ROWS, 9'd3);
        write_reg(REG_COLS, 9'd4);
        for (int k = 0; k < 3 * DIM_MIN; k++) push_word(pick_sample(), k == 0);
        wait_drained();
        write_reg(REG_COLS, 9'd511);
        for (int k = 0; k < MAX_COLS; k++) push_word(pick_sample(), 1'b0);
        wait_drained();

        if (sums_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", sums_due.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* window_core_ring_sums_4x4_top.f */
rtl/ws44_pkg.sv
rtl/ws44_pos.sv
rtl/ws44_line.sv
rtl/ws44_window.sv
rtl/window_core_ring_sums_4x4_top.sv
sim/tb_top.sv
